/* design/fir_filter_stream_top_assert.svh */
// assertion macros for the fir filter stream top level
`ifndef FIR_FILTER_STREAM_TOP_ASSERT_SVH
`define FIR_FILTER_STREAM_TOP_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define FIR_FS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must hold in the cycle after the trigger
`define FIR_FS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/fir_fs_pkg.sv */
// shared constants and types for the fir filter stream
package fir_fs_pkg;

	localparam int MAX_TAPS    = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS   = 16;
	localparam int ORDER_BITS  = 6;
	localparam int INDEX_BITS  = 6;

	localparam int TAP_AW = $clog2(MAX_TAPS);
	localparam int FILL_W = $clog2(MAX_TAPS + 1);

	// radix-16 serial multiplier over the sample
	localparam int DIGIT_BITS = 4;
	localparam int DIGITS     = (SAMPLE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int SX         = DIGITS * DIGIT_BITS;
	localparam int DIG_W      = $clog2(DIGITS);
	localparam int PART_W     = COEF_BITS + DIGIT_BITS + 1;

	localparam int PROD_W    = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_W     = PROD_W + TAP_AW;
	localparam int FRAC_BITS = COEF_BITS - 1;
	localparam int RND_W     = ACC_W - FRAC_BITS;
	localparam int HALF      = 1 << (FRAC_BITS - 1);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef struct packed {
		logic load;
		logic step;
	} mul_ctrl_t;

	typedef struct packed {
		logic clear;
		logic add;
		logic round;
	} acc_ctrl_t;

endpackage

/* design/fir_fs_if.sv */
// stream channel interfaces for the fir filter
interface fir_fs_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 kind;
	fir_fs_pkg::sample_t                  sample_in;
	logic [fir_fs_pkg::INDEX_BITS-1:0]    tap_index;
	fir_fs_pkg::coef_t                    tap_value;

	modport source (output valid, kind, sample_in, tap_index, tap_value, input ready);
	modport sink (input valid, kind, sample_in, tap_index, tap_value, output ready);
endinterface

interface fir_fs_out_if;
	logic                valid;
	logic                ready;
	fir_fs_pkg::sample_t sample_out;

	modport source (output valid, sample_out, input ready);
	modport sink (input valid, sample_out, output ready);
endinterface

/* design/fir_fs_ram.sv */
// generic single write port ram with registered read
module fir_fs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/fir_fs_mul.sv */
// digit-serial signed multiplier, one radix-16 digit of the sample per cycle while step is high
module fir_fs_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fir_fs_pkg::mul_ctrl_t             ctrl,
	input  fir_fs_pkg::coef_t                 coef,
	input  fir_fs_pkg::sample_t               sample,
	output logic                              last_digit,
	output logic signed [fir_fs_pkg::PROD_W-1:0] product
);

	fir_fs_pkg::coef_t                          coef_q;
	logic [fir_fs_pkg::SX-1:0]                  sh_q;
	logic signed [fir_fs_pkg::PART_W-1:0]       hi_q;
	logic [fir_fs_pkg::SX-1:0]                  lo_q;
	logic [fir_fs_pkg::DIG_W-1:0]               dig_q;

	logic [fir_fs_pkg::DIGIT_BITS-1:0]          digit;
	logic signed [fir_fs_pkg::DIGIT_BITS:0]     digit_ext;
	logic signed [fir_fs_pkg::PART_W-1:0]       part;
	logic signed [fir_fs_pkg::PART_W-1:0]       sum;
	logic [fir_fs_pkg::PART_W+fir_fs_pkg::SX-1:0] full;

	assign last_digit = (dig_q == fir_fs_pkg::DIG_W'(fir_fs_pkg::DIGITS - 1));

	// lower digits are unsigned, the top digit carries the sign
	always_comb begin
		digit     = sh_q[fir_fs_pkg::DIGIT_BITS-1:0];
		digit_ext = {last_digit ? digit[fir_fs_pkg::DIGIT_BITS-1] : 1'b0, digit};
		part      = fir_fs_pkg::PART_W'(coef_q) * fir_fs_pkg::PART_W'(digit_ext);
		sum       = hi_q + part;
		full      = {hi_q, lo_q};
	end

	assign product = full[fir_fs_pkg::PROD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_q <= '0;
		end else if (ctrl.load) begin
			dig_q <= '0;
		end else if (ctrl.step) begin
			dig_q <= dig_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			coef_q <= coef;
			sh_q   <= fir_fs_pkg::SX'(sample);
			hi_q   <= '0;
		end else if (ctrl.step) begin
			hi_q <= sum >>> fir_fs_pkg::DIGIT_BITS;
			lo_q <= {sum[fir_fs_pkg::DIGIT_BITS-1:0], lo_q[fir_fs_pkg::SX-1:fir_fs_pkg::DIGIT_BITS]};
			sh_q <= sh_q >> fir_fs_pkg::DIGIT_BITS;
		end
	end

endmodule

/* design/fir_fs_acc.sv */
// tap accumulator with round to nearest and saturation
module fir_fs_acc (
	input  logic                                 clk,
	input  fir_fs_pkg::acc_ctrl_t                ctrl,
	input  logic signed [fir_fs_pkg::PROD_W-1:0] product,
	output fir_fs_pkg::sample_t                  result
);

	localparam logic signed [fir_fs_pkg::RND_W-1:0] RND_MAX =
		fir_fs_pkg::RND_W'(fir_fs_pkg::SAMPLE_MAX);
	localparam logic signed [fir_fs_pkg::RND_W-1:0] RND_MIN =
		fir_fs_pkg::RND_W'(fir_fs_pkg::SAMPLE_MIN);

	logic signed [fir_fs_pkg::ACC_W-1:0] acc_q;
	logic signed [fir_fs_pkg::RND_W-1:0] rnd_q;
	logic signed [fir_fs_pkg::ACC_W-1:0] biased;

	assign biased = acc_q + fir_fs_pkg::ACC_W'(fir_fs_pkg::HALF);

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.add) begin
			acc_q <= acc_q + fir_fs_pkg::ACC_W'(product);
		end
		// dropping the fraction bits floors toward minus infinity
		if (ctrl.round) begin
			rnd_q <= biased[fir_fs_pkg::ACC_W-1:fir_fs_pkg::FRAC_BITS];
		end
	end

	always_comb begin
		if (rnd_q > RND_MAX) begin
			result = fir_fs_pkg::SAMPLE_MAX;
		end else if (rnd_q < RND_MIN) begin
			result = fir_fs_pkg::SAMPLE_MIN;
		end else begin
			result = rnd_q[fir_fs_pkg::SAMPLE_BITS-1:0];
		end
	end

endmodule

/* design/fir_filter_stream_top.sv */
// fir filter stream top level: control sequencer, delay line and coefficient stores
//
//  channel   dir   handshake       payload
//  in_ch     in    valid / ready   kind, sample_in, tap_index, tap_value
//  out_ch    out   valid / ready   sample_out
//  cfg       in    cfg_we          cfg_wdata (filter order)
//
// a sample sums J+1 taps, J = min(order, MAX_TAPS-1):
// each tap takes one load, four multiplier digit steps and one accumulate
// a coefficient write leaves the sequencer idle; the input is ready only between samples
// reset clears the delay line fill count and coefficient valid bits, no clearing pass
// a stalled result waits in the output register; the sequencer holds until it is free
module fir_filter_stream_top (
	input  logic                              clk,
	input  logic                              arst_n,
	fir_fs_in_if.sink                         in_ch,
	fir_fs_out_if.source                      out_ch,
	input  logic                              cfg_we,
	input  logic [fir_fs_pkg::ORDER_BITS-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WAIT,
		ST_LOAD,
		ST_MUL,
		ST_ACC,
		ST_ROUND,
		ST_DONE
	} state_t;

	state_t                             state_q;
	logic [fir_fs_pkg::ORDER_BITS-1:0]  order_q;
	logic [fir_fs_pkg::TAP_AW-1:0]      head_q;
	logic [fir_fs_pkg::FILL_W-1:0]      fill_q;
	logic [fir_fs_pkg::TAP_AW-1:0]      tap_q;
	logic [fir_fs_pkg::TAP_AW-1:0]      last_q;
	logic                               final_q;
	logic                               ok_q;
	logic [fir_fs_pkg::MAX_TAPS-1:0]    coef_vld_q;
	logic                               out_valid_q;
	fir_fs_pkg::sample_t                out_data_q;

	logic                               in_acc;
	logic [31:0]                        ord_ext;
	logic [31:0]                        idx_ext;
	logic                               idx_ok;
	logic [fir_fs_pkg::TAP_AW-1:0]      last_lim;
	logic [fir_fs_pkg::TAP_AW-1:0]      coef_waddr;
	logic [fir_fs_pkg::TAP_AW-1:0]      dly_waddr;
	logic [fir_fs_pkg::TAP_AW-1:0]      dly_raddr;
	logic                               dly_we;
	logic                               coef_we;
	fir_fs_pkg::sample_t                dly_rd;
	fir_fs_pkg::coef_t                  coef_rd;
	fir_fs_pkg::sample_t                mul_sample;
	fir_fs_pkg::coef_t                  mul_coef;
	fir_fs_pkg::mul_ctrl_t              mul_ctrl;
	fir_fs_pkg::acc_ctrl_t              acc_ctrl;
	logic                               mul_last;
	logic signed [fir_fs_pkg::PROD_W-1:0] product;
	fir_fs_pkg::sample_t                acc_result;

	assign in_ch.ready       = (state_q == ST_IDLE);
	assign in_acc            = in_ch.valid && in_ch.ready;
	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = out_data_q;

	always_comb begin
		ord_ext    = 32'(order_q);
		idx_ext    = 32'(in_ch.tap_index);
		idx_ok     = idx_ext < 32'(fir_fs_pkg::MAX_TAPS);
		coef_waddr = idx_ext[fir_fs_pkg::TAP_AW-1:0];
		if (ord_ext > 32'(fir_fs_pkg::MAX_TAPS - 1)) begin
			last_lim = fir_fs_pkg::TAP_AW'(fir_fs_pkg::MAX_TAPS - 1);
		end else begin
			last_lim = ord_ext[fir_fs_pkg::TAP_AW-1:0];
		end
	end

	// circular delay line, head points at the newest sample
	assign dly_we    = in_acc && !in_ch.kind;
	assign dly_waddr = head_q + 1'b1;
	assign dly_raddr = head_q - tap_q;
	assign coef_we   = in_acc && in_ch.kind && idx_ok;

	fir_fs_ram #(
		.WIDTH (fir_fs_pkg::SAMPLE_BITS),
		.DEPTH (fir_fs_pkg::MAX_TAPS)
	) u_dly_ram (
		.clk   (clk),
		.we    (dly_we),
		.waddr (dly_waddr),
		.wdata (in_ch.sample_in),
		.raddr (dly_raddr),
		.rdata (dly_rd)
	);

	fir_fs_ram #(
		.WIDTH (fir_fs_pkg::COEF_BITS),
		.DEPTH (fir_fs_pkg::MAX_TAPS)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_waddr),
		.wdata (in_ch.tap_value),
		.raddr (tap_q),
		.rdata (coef_rd)
	);

	// unwritten coefficients and samples older than reset read as zero
	assign mul_coef   = ok_q ? coef_rd : '0;
	assign mul_sample = ok_q ? dly_rd : '0;

	always_comb begin
		mul_ctrl.load  = (state_q == ST_LOAD);
		mul_ctrl.step  = (state_q == ST_MUL);
		acc_ctrl.clear = dly_we;
		acc_ctrl.add   = (state_q == ST_ACC);
		acc_ctrl.round = (state_q == ST_ROUND);
	end

	fir_fs_mul u_mul (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (mul_ctrl),
		.coef       (mul_coef),
		.sample     (mul_sample),
		.last_digit (mul_last),
		.product    (product)
	);

	fir_fs_acc u_acc (
		.clk     (clk),
		.ctrl    (acc_ctrl),
		.product (product),
		.result  (acc_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= '0;
		end else if (cfg_we) begin
			order_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			fill_q      <= '0;
			tap_q       <= '0;
			last_q      <= '0;
			final_q     <= 1'b0;
			ok_q        <= 1'b0;
			coef_vld_q  <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// tracks the ram read issued this cycle
			ok_q <= coef_vld_q[tap_q] && (fir_fs_pkg::FILL_W'(tap_q) < fill_q);
			// the done step handles the output register itself
			if (out_valid_q && out_ch.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (coef_we) begin
						coef_vld_q[coef_waddr] <= 1'b1;
					end
					if (dly_we) begin
						head_q <= dly_waddr;
						tap_q  <= '0;
						last_q <= last_lim;
						if (fill_q != fir_fs_pkg::FILL_W'(fir_fs_pkg::MAX_TAPS)) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					final_q <= (tap_q == last_q);
					tap_q   <= tap_q + 1'b1;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mul_last) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					state_q <= final_q ? ST_ROUND : ST_LOAD;
				end
				ST_ROUND: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= acc_result;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`include "fir_filter_stream_top_assert.svh"

	`FIR_FS_ASSERT_NEXT(a_sample_starts, in_acc && !in_ch.kind, state_q == ST_WAIT && tap_q == '0, "sample transaction did not start the tap sweep")
	`FIR_FS_ASSERT_NEXT(a_coef_no_sweep, in_acc && in_ch.kind, state_q == ST_IDLE, "coefficient transaction left idle")
	`FIR_FS_ASSERT_SAME(a_acc_after_mul, state_q == ST_ACC, $past(state_q) == ST_MUL, "accumulate without a finished product")
	`FIR_FS_ASSERT_SAME(a_out_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE, "result raised outside the done step")

endmodule
